FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

FILE: hw/rtl/xyfr_pkg.sv
// Shared types and constants for the xy frame receiver.
// No dependencies.
package xyfr_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'hFE;

  localparam logic [COORD_W-1:0] X_LIMIT_RESET = 10'd400;
  localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 10'd240;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LIMIT = 2'd0,
    CFG_Y_LIMIT = 2'd1
  } cfg_reg_t;

  typedef logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_limit;
    logic [COORD_W-1:0] y_limit;
  } limits_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

FILE: hw/rtl/xyfr_front.sv
// Front end: accepts rx bytes, tracks framing and the payload bytes.
// Pushes a frame snapshot into the queue on each frame end. Uses xyfr_pkg.
module xyfr_front #(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [xyfr_pkg::BYTE_W-1:0]   rx_byte,
  input  xyfr_pkg::queue_status_t       queue_status,
  output logic                          push,
  output xyfr_pkg::frame_t              push_frame
);
  import xyfr_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_LEN + 1);
  localparam logic [IdxW-1:0] MaxLen = IdxW'(MAX_LEN);

  logic            receiving, receiving_next;
  logic [IdxW-1:0] fill_index, fill_index_next;
  frame_t          frame_bytes, frame_bytes_next;
  logic            accept;
  logic            frame_end;

  assign in_ready = !queue_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    receiving_next   = receiving;
    fill_index_next  = fill_index;
    frame_bytes_next = frame_bytes;
    frame_end        = 1'b0;
    if (accept) begin
      if (!receiving) begin
        if (rx_byte == HEAD_BYTE) begin
          receiving_next  = 1'b1;
          fill_index_next = IdxW'(1);
        end
      end else begin
        if (fill_index < MaxLen) begin
          for (int i = 0; i < FRAME_BYTES; i++) begin
            if (fill_index == IdxW'(i + 1)) begin
              frame_bytes_next[i] = rx_byte;
            end
          end
          fill_index_next = fill_index + 1'b1;
        end else begin
          // overflow byte: not stored, reception stops
          receiving_next  = 1'b0;
          fill_index_next = '0;
        end
        if (rx_byte == TAIL_BYTE) begin
          receiving_next = 1'b0;
          frame_end      = 1'b1;
        end
      end
    end
  end

  assign push       = frame_end;
  assign push_frame = frame_bytes_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving   <= 1'b0;
      fill_index  <= '0;
      frame_bytes <= '0;
    end else begin
      receiving   <= receiving_next;
      fill_index  <= fill_index_next;
      frame_bytes <= frame_bytes_next;
    end
  end

endmodule

FILE: hw/rtl/xyfr_queue.sv
// Short queue of frame snapshots between front and back end.
// Uses xyfr_pkg for depth and entry type.
module xyfr_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  xyfr_pkg::frame_t        push_frame,
  input  logic                    pop,
  output xyfr_pkg::frame_t        pop_frame,
  output xyfr_pkg::queue_status_t status
);
  import xyfr_pkg::*;

  frame_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_frame    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/xyfr_back.sv
// Back end: decodes a frame into four coordinates, range checks them
// and holds the result in the output register. Uses xyfr_pkg.
module xyfr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  xyfr_pkg::frame_t              pop_frame,
  input  xyfr_pkg::queue_status_t       queue_status,
  output logic                          pop,
  input  xyfr_pkg::limits_t             limits,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [xyfr_pkg::COORD_W-1:0]  tgt_x,
  output logic [xyfr_pkg::COORD_W-1:0]  tgt_y,
  output logic [xyfr_pkg::COORD_W-1:0]  cur_x,
  output logic [xyfr_pkg::COORD_W-1:0]  cur_y,
  output logic                          in_range
);
  import xyfr_pkg::*;

  localparam int unsigned NumWords = FRAME_BYTES / 2;
  localparam int unsigned WordW    = 2 * BYTE_W;

  logic [WordW-1:0]   words   [NumWords];
  logic [COORD_W-1:0] lims    [NumWords];
  logic [COORD_W-1:0] coords  [NumWords];
  logic [NumWords-1:0] word_ok;
  logic               all_ok;

  always_comb begin
    for (int k = 0; k < NumWords; k++) begin
      words[k]   = {pop_frame[2*k+1], pop_frame[2*k]};
      lims[k]    = (k % 2 == 0) ? limits.x_limit : limits.y_limit;
      word_ok[k] = !words[k][WordW-1] &&
                   (words[k][WordW-2:0] <= (WordW-1)'(lims[k]));
    end
    all_ok = &word_ok;
    for (int k = 0; k < NumWords; k++) begin
      coords[k] = all_ok ? words[k][COORD_W-1:0] : '0;
    end
  end

  assign pop = !queue_status.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      tgt_x    <= coords[0];
      tgt_y    <= coords[1];
      cur_x    <= coords[2];
      cur_y    <= coords[3];
      in_range <= all_ok;
    end
  end

endmodule

FILE: hw/rtl/xy_frame_receiver_unit.sv
// Top level of the xy frame receiver: config registers, front end,
// snapshot queue and back end. Uses xyfr_pkg and assert_macros.svh.
//
// Usage:
// - in channel (in_valid/in_ready/rx_byte): one received byte per beat.
//   0xFF while idle opens a frame, 0xFE while receiving closes it.
// - out channel (out_valid/out_ready + coordinate fields): one beat per
//   frame end, with four decoded coordinates and in_range; when any value
//   is negative or above its limit, in_range is 0 and all coordinates 0.
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes x_limit
//   (index 0) or y_limit (index 1); always ready. Write only while idle.
// Throughput: one byte per cycle while in_ready is high. Path: the queue
// is written at the edge that accepts the closing byte, and the output
// register loads the frame from the queue when it is free to take it.
// Stall: while out_ready is low, one finished frame waits in the output
// register and up to two more in the queue; in_ready drops while the
// queue is full. Reset: synchronous, clears framing state, payload bytes
// and the queue, and restores the limits to 400 and 240.
`include "assert_macros.svh"

module xy_frame_receiver_unit #(
  parameter int unsigned MAX_LEN = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [xyfr_pkg::BYTE_W-1:0]     rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [xyfr_pkg::COORD_W-1:0]    tgt_x,
  output logic [xyfr_pkg::COORD_W-1:0]    tgt_y,
  output logic [xyfr_pkg::COORD_W-1:0]    cur_x,
  output logic [xyfr_pkg::COORD_W-1:0]    cur_y,
  output logic                            in_range,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xyfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xyfr_pkg::COORD_W-1:0]    cfg_data
);
  import xyfr_pkg::*;

  limits_t       limits;
  queue_status_t queue_status;
  logic          push, pop;
  frame_t        push_frame, pop_frame;
  logic          coords_zero;
  logic          coords_in_limits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.x_limit <= X_LIMIT_RESET;
      limits.y_limit <= Y_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_LIMIT: limits.x_limit <= cfg_data;
        CFG_Y_LIMIT: limits.y_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  xyfr_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .queue_status (queue_status),
    .push         (push),
    .push_frame   (push_frame)
  );

  xyfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .status     (queue_status)
  );

  xyfr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_frame    (pop_frame),
    .queue_status (queue_status),
    .pop          (pop),
    .limits       (limits),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tgt_x        (tgt_x),
    .tgt_y        (tgt_y),
    .cur_x        (cur_x),
    .cur_y        (cur_y),
    .in_range     (in_range)
  );

  assign coords_zero = (tgt_x == '0) && (tgt_y == '0) && (cur_x == '0) && (cur_y == '0);
  assign coords_in_limits = (tgt_x <= limits.x_limit) && (tgt_y <= limits.y_limit) &&
                            (cur_x <= limits.x_limit) && (cur_y <= limits.y_limit);

  `ASSERT_IMPLIES(a_zero_when_out_of_range, clk, rst, out_valid && !in_range, coords_zero)
  `ASSERT_IMPLIES(a_within_limits, clk, rst, out_valid && in_range, coords_in_limits)
  `ASSERT_NEXT(a_push_lands, clk, rst, push, !queue_status.empty)
  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst, queue_status.full, !push)

endmodule
